// ----- rtl/altfl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// altfl_pkg
// Shared types, register indexes and helpers for the altitude floor block.
// ============================================================================
package altfl_pkg;

    // receiver stick centre position, raw units
    localparam int STICK_CENTER = 1500;

    // orbit bank and pitch limits, centidegrees
    localparam logic [11:0]        ORBIT_BANK_CDEG = 12'd2200;
    localparam logic signed [25:0] ORBIT_PITCH_MIN = -26'sd500;
    localparam logic signed [25:0] ORBIT_PITCH_MAX = 26'sd1000;

    // configuration register indexes
    localparam logic [1:0] REG_FLOOR_ALT   = 2'd0;
    localparam logic [1:0] REG_FLOOR_MRG   = 2'd1;
    localparam logic [1:0] REG_CLIMB_PITCH = 2'd2;
    localparam logic [1:0] REG_DEADBAND    = 2'd3;

    // widths of the config port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 14;

    // packed stream widths (padded to whole bytes)
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 120;

    // derived settings handed from the register file to the core
    typedef struct packed {
        logic [20:0] floor_cm;
        logic [20:0] top_cm;
        logic [14:0] climb_cdeg;
        logic [7:0]  deadband;
    } cfg_t;

    // one input item
    typedef struct packed {
        logic               enabled;
        logic signed [23:0] altitude_cm;
        logic signed [15:0] climb_rate_cms;
        logic signed [31:0] position_x_cm;
        logic signed [31:0] position_y_cm;
        logic               position_healthy;
        logic [11:0]        roll_stick;
        logic [11:0]        pitch_stick;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic               floor_armed;
        logic               recovery_active;
        logic               orbit_active;
        logic               orbit_by_nav;
        logic               nav_activate;
        logic               nav_assert;
        logic               nav_abort;
        logic signed [31:0] anchor_x_cm;
        logic signed [31:0] anchor_y_cm;
        logic [20:0]        anchor_z_cm;
        logic signed [14:0] pitch_cmd_cdeg;
        logic [11:0]        roll_cmd_cdeg;
    } result_t;

    // stick offset from centre beyond the deadband
    function automatic logic stick_deflected(input logic [11:0] raw, input logic [7:0] band);
        logic signed [12:0] d;
        logic [12:0]        mag;
        d   = $signed({1'b0, raw}) - $signed(13'(STICK_CENTER));
        mag = d[12] ? (~d + 13'd1) : d;
        return mag > {5'b0, band};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/altitude_floor_recovery_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// altitude_floor_recovery_fsm
// Altitude floor guard with climb, orbit and stick release, one item a tick.
// ============================================================================
// Usage:
//   s_ carries one control tick's sensor and stick item, m_ one command item
//   per input item, in order. The cfg_ port writes the floor, margin, climb
//   pitch and deadband registers; write only while no item is in flight.
//   Path: an accepted item passes the input register, then the result
//   register, with the state update between them.
//   Throughput: one item per clock while m_tready stays high; the state
//   flags feed back before the next item, so consecutive items need no gap.
//   Stall: when m_tready is low the result register holds and the input
//   register still takes one more item; after that s_tready drops until the
//   result is taken.
//   Reset (aresetn low, synchronous): all flags and the anchor clear to zero,
//   the registers return to 50 m floor, 10 m margin, 20 deg climb and
//   deadband 5, and both channels come up empty.
// ============================================================================
module altitude_floor_recovery_fsm (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // config write port
    input  wire logic                             cfg_we,
    input  wire logic [altfl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [altfl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // enabled, altitude_cm, climb_rate_cms, position_x_cm, position_y_cm,
    // position_healthy, roll_stick, pitch_stick, zero pad
    input  wire logic [altfl_pkg::IN_DATA_W-1:0]  s_tdata,
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // floor_armed, recovery_active, orbit_active, orbit_by_nav, nav_activate,
    // nav_assert, nav_abort, anchor_x_cm, anchor_y_cm, anchor_z_cm,
    // pitch_cmd_cdeg, roll_cmd_cdeg, zero pad
    output logic [altfl_pkg::OUT_DATA_W-1:0]      m_tdata
);

    altfl_pkg::cfg_t     cfg;
    altfl_pkg::in_item_t item_reg;
    altfl_pkg::result_t  res, res_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                fire;

    altfl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // pipeline handshake
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.enabled          <= s_tdata[0];
            item_reg.altitude_cm      <= s_tdata[24:1];
            item_reg.climb_rate_cms   <= s_tdata[40:25];
            item_reg.position_x_cm    <= s_tdata[72:41];
            item_reg.position_y_cm    <= s_tdata[104:73];
            item_reg.position_healthy <= s_tdata[105];
            item_reg.roll_stick       <= s_tdata[117:106];
            item_reg.pitch_stick      <= s_tdata[129:118];
        end
    end

    altfl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    // pack result fields, lowest first
    assign m_tvalid         = out_valid_reg;
    assign m_tdata[0]       = res_reg.floor_armed;
    assign m_tdata[1]       = res_reg.recovery_active;
    assign m_tdata[2]       = res_reg.orbit_active;
    assign m_tdata[3]       = res_reg.orbit_by_nav;
    assign m_tdata[4]       = res_reg.nav_activate;
    assign m_tdata[5]       = res_reg.nav_assert;
    assign m_tdata[6]       = res_reg.nav_abort;
    assign m_tdata[38:7]    = res_reg.anchor_x_cm;
    assign m_tdata[70:39]   = res_reg.anchor_y_cm;
    assign m_tdata[91:71]   = res_reg.anchor_z_cm;
    assign m_tdata[106:92]  = res_reg.pitch_cmd_cdeg;
    assign m_tdata[118:107] = res_reg.roll_cmd_cdeg;
    assign m_tdata[119]     = 1'b0;

endmodule
`default_nettype wire

// ----- rtl/altfl_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// altfl_cfg
// Configuration registers and their centimetre / centidegree forms.
// ============================================================================
module altfl_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [altfl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [altfl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output altfl_pkg::cfg_t                      cfg
);

    logic [13:0] floor_m_reg;
    logic [9:0]  margin_m_reg;
    logic [6:0]  pitch_deg_reg;
    logic [7:0]  band_reg;
    logic [20:0] floor_cm;
    logic [20:0] margin_cm;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_m_reg   <= 14'd50;
            margin_m_reg  <= 10'd10;
            pitch_deg_reg <= 7'd20;
            band_reg      <= 8'd5;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                altfl_pkg::REG_FLOOR_ALT:   floor_m_reg   <= cfg_wdata[13:0];
                altfl_pkg::REG_FLOOR_MRG:   margin_m_reg  <= cfg_wdata[9:0];
                altfl_pkg::REG_CLIMB_PITCH: pitch_deg_reg <= cfg_wdata[6:0];
                altfl_pkg::REG_DEADBAND:    band_reg      <= cfg_wdata[7:0];
            endcase
        end
    end

    // scale metres to cm and degrees to centidegrees
    assign floor_cm       = {7'b0, floor_m_reg} * 21'd100;
    assign margin_cm      = {11'b0, margin_m_reg} * 21'd100;
    assign cfg.floor_cm   = floor_cm;
    assign cfg.top_cm     = floor_cm + margin_cm;
    assign cfg.climb_cdeg = {8'b0, pitch_deg_reg} * 15'd100;
    assign cfg.deadband   = band_reg;

endmodule
`default_nettype wire

// ----- rtl/altfl_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// altfl_core
// Recovery state flags, anchor latch and command computation for one item.
// ============================================================================
module altfl_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire altfl_pkg::in_item_t item,
    input  wire altfl_pkg::cfg_t     cfg,
    output altfl_pkg::result_t      res
);

    logic               armed_reg, armed_next;
    logic               rec_reg, rec_next;
    logic               orbit_reg, orbit_next;
    logic               nav_reg, nav_next;
    logic               cent_reg, cent_next;
    logic signed [31:0] ax_reg, ax_next;
    logic signed [31:0] ay_reg, ay_next;
    logic [20:0]        az_reg, az_next;
    logic               act, asrt, abrt, defl;
    logic signed [24:0] z_ext, floor_ext, top_ext;
    logic signed [25:0] pdiff, pclamp;

    assign z_ext     = {item.altitude_cm[23], item.altitude_cm};
    assign floor_ext = $signed({4'b0, cfg.floor_cm});
    assign top_ext   = $signed({4'b0, cfg.top_cm});
    assign defl      = altfl_pkg::stick_deflected(item.roll_stick, cfg.deadband)
                     || altfl_pkg::stick_deflected(item.pitch_stick, cfg.deadband);

    // state transition for one item
    always_comb begin
        armed_next = armed_reg;
        rec_next   = rec_reg;
        orbit_next = orbit_reg;
        nav_next   = nav_reg;
        cent_next  = cent_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        act        = 1'b0;
        asrt       = 1'b0;
        abrt       = 1'b0;
        if (!item.enabled) begin
            armed_next = 1'b0;
            rec_next   = 1'b0;
            orbit_next = 1'b0;
            if (nav_reg) begin
                abrt     = 1'b1;
                nav_next = 1'b0;
            end
        end else if (!armed_reg) begin
            armed_next = z_ext > top_ext;
        end else if (!rec_reg) begin
            if (item.climb_rate_cms < 0 && z_ext < floor_ext) begin
                rec_next   = 1'b1;
                orbit_next = 1'b0;
                cent_next  = 1'b0;
                ax_next    = item.position_x_cm;
                ay_next    = item.position_y_cm;
                az_next    = cfg.top_cm;
            end
        end else begin
            // climb ends above floor plus margin
            if (!orbit_reg && z_ext > top_ext && item.climb_rate_cms > 0) begin
                orbit_next = 1'b1;
                if (item.position_healthy) begin
                    act      = 1'b1;
                    nav_next = 1'b1;
                end
            end
            asrt = nav_next;
            // pilot release: centre first, then deflect
            if (!cent_reg) begin
                cent_next = !defl;
            end else if (defl) begin
                rec_next   = 1'b0;
                orbit_next = 1'b0;
                if (nav_next) begin
                    abrt     = 1'b1;
                    nav_next = 1'b0;
                end
            end
        end
    end

    // orbit pitch toward anchor altitude, clamped
    always_comb begin
        pdiff = $signed({5'b0, cfg.top_cm}) - {{2{item.altitude_cm[23]}}, item.altitude_cm};
        priority if (pdiff < altfl_pkg::ORBIT_PITCH_MIN) begin
            pclamp = altfl_pkg::ORBIT_PITCH_MIN;
        end else if (pdiff > altfl_pkg::ORBIT_PITCH_MAX) begin
            pclamp = altfl_pkg::ORBIT_PITCH_MAX;
        end else begin
            pclamp = pdiff;
        end
    end

    // result fields after the update
    assign res.floor_armed     = armed_next;
    assign res.recovery_active = rec_next;
    assign res.orbit_active    = orbit_next;
    assign res.orbit_by_nav    = nav_next;
    assign res.nav_activate    = act;
    assign res.nav_assert      = asrt;
    assign res.nav_abort       = abrt;
    assign res.anchor_x_cm     = ax_next;
    assign res.anchor_y_cm     = ay_next;
    assign res.anchor_z_cm     = az_next;
    assign res.pitch_cmd_cdeg  = orbit_next ? pclamp[14:0] : $signed(cfg.climb_cdeg);
    assign res.roll_cmd_cdeg   = (orbit_next && !nav_next) ? altfl_pkg::ORBIT_BANK_CDEG
                                                           : 12'd0;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            rec_reg   <= 1'b0;
            orbit_reg <= 1'b0;
            nav_reg   <= 1'b0;
            cent_reg  <= 1'b0;
            ax_reg    <= '0;
            ay_reg    <= '0;
            az_reg    <= '0;
        end else if (fire) begin
            armed_reg <= armed_next;
            rec_reg   <= rec_next;
            orbit_reg <= orbit_next;
            nav_reg   <= nav_next;
            cent_reg  <= cent_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            az_reg    <= az_next;
        end
    end

    // flag hierarchy: nav orbit inside orbit inside recovery inside armed
    a_nav_in_orbit: assert property (@(posedge aclk) disable iff (!aresetn)
        nav_reg |-> orbit_reg) else $error("nav orbit without orbit phase");
    a_orbit_in_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        orbit_reg |-> rec_reg) else $error("orbit phase without recovery");
    a_rec_in_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_reg |-> armed_reg) else $error("recovery while not armed");
    a_abort_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && abrt |=> !nav_reg) else $error("nav orbit kept after abort");

endmodule
`default_nettype wire
